// ===== rtl/sspt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sspt_pkg;

  // default bitmap size limits
  localparam int MAX_BITMAP_WIDTH_DEF  = 128;
  localparam int MAX_BITMAP_HEIGHT_DEF = 128;

  // value written over a foreground pixel
  localparam logic [7:0] FG_PIXEL = 8'd160;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_BITMAP_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_BITMAP_HEIGHT = 3'd3;
  localparam cfg_idx_t CFG_ASPECT_DOUBLE = 3'd4;

  // input word function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  // scale recompute sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEL,
    ST_DIV,
    ST_OFF
  } cfg_state_t;

  // bits in the offset dividend
  localparam int DIV_STEPS = 22;

endpackage

`default_nettype wire

// ===== rtl/sspt_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sspt_item_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [10:0] load_addr;
  logic [7:0]  load_byte;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  pixel_in;

  modport source (output valid, func, load_addr, load_byte, pixel_x, pixel_y, pixel_in,
                  input ready);
  modport sink   (input valid, func, load_addr, load_byte, pixel_x, pixel_y, pixel_in,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sspt_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sspt_result_if;
  logic       valid;
  logic       ready;
  logic       foreground;
  logic [7:0] pixel_out;

  modport source (output valid, foreground, pixel_out, input ready);
  modport sink   (input valid, foreground, pixel_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/sspt_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sspt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/scaled_stencil_pixel_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stencil overlay on a pixel stream. Load words write one bitmap byte, test
// words map a screen pixel into the bitmap and return one result word
// (foreground flag and pixel 160 or the pixel unchanged); load words return
// nothing. The test path is a 10-stage pipeline (offset, multiply, range
// check, four stages of two quotient bits each, address, bitmap RAM read,
// output register) and takes one word per clock while it is not stalled;
// back-pressure on the result side stalls the whole pipeline. A write to one
// of the five configuration registers makes the scale sequencer busy
// (multiply, select, bit-serial divide of the 22-bit dividend, offset) to
// recompute the scale and offset; no input word is taken during that time.
module scaled_stencil_pixel_test import sspt_pkg::*; #(
  parameter int MAX_BITMAP_WIDTH  = MAX_BITMAP_WIDTH_DEF,
  parameter int MAX_BITMAP_HEIGHT = MAX_BITMAP_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sspt_item_if.sink     items,
  sspt_result_if.source results,
  sspt_cfg_if.sink      cfg
);

  localparam int DEPTH = ((MAX_BITMAP_WIDTH + 7) / 8) * MAX_BITMAP_HEIGHT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int AW    = (IDX_W + 1 > 14) ? IDX_W + 1 : 14;

  function automatic logic [22:0] div_step(input logic [21:0] r, input logic [21:0] ds);
    return (r >= ds) ? {1'b1, r - ds} : {1'b0, r};
  endfunction

  // configuration registers and scale factors
  logic [12:0] sw, sh;
  logic [7:0]  bw, bh;
  logic        adbl;
  logic [8:0]  xnum, ynum;
  logic [12:0] xden;
  logic [13:0] yden;
  logic [12:0] xoff, yoff;
  logic [21:0] bndx, bndy;

  // sequencer
  cfg_state_t  state, state_next;
  logic        cfg_busy, cfg_hit;
  logic [21:0] pa, pb;
  logic        fitw;
  logic [21:0] div_d;
  logic [8:0]  div_r, divisor;
  logic [4:0]  div_cnt;
  logic [9:0]  div_t;
  logic [21:0] div_q;

  always_comb begin
    unique case (cfg.index)
      CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_BITMAP_WIDTH,
      CFG_BITMAP_HEIGHT, CFG_ASPECT_DOUBLE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cfg.valid && cfg_hit) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SEL;
      ST_SEL:  state_next = ST_DIV;
      ST_DIV:  if (div_cnt == 5'(DIV_STEPS - 1)) state_next = ST_OFF;
      ST_OFF:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    unique case (state)
      ST_IDLE: cfg_busy = 1'b0;
      default: cfg_busy = 1'b1;
    endcase
  end
  assign cfg.ready = !cfg_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign div_t = {div_r, div_d[21]};
  assign div_q = (divisor == 9'd0) ? 22'd0 : div_d;

  // register writes and scale recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= 13'd640; sh <= 13'd480; bw <= 8'd128; bh <= 8'd128; adbl <= 1'b0;
      xnum <= '0; xden <= '0; xoff <= '0;
      ynum <= '0; yden <= '0; yoff <= '0;
      bndx <= '0; bndy <= '0;
      div_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg.valid) begin
            case (cfg.index)
              CFG_SCREEN_WIDTH:  sw   <= cfg.data;
              CFG_SCREEN_HEIGHT: sh   <= cfg.data;
              CFG_BITMAP_WIDTH:  bw   <= cfg.data[7:0];
              CFG_BITMAP_HEIGHT: bh   <= cfg.data[7:0];
              CFG_ASPECT_DOUBLE: adbl <= cfg.data[0];
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          pa <= (22'(sw) * 22'(bh)) << adbl;
          pb <= 22'(sh) * 22'(bw);
        end
        ST_SEL: begin
          fitw    <= pa < pb;
          div_r   <= '0;
          div_cnt <= '0;
          if (pa < pb) begin
            xnum    <= 9'(bw);
            xden    <= sw;
            ynum    <= 9'(bw);
            yden    <= 14'(sw) << adbl;
            div_d   <= 22'(bh) * (22'(sw) << adbl);
            divisor <= 9'(bw);
          end else begin
            xnum    <= 9'(bh) << adbl;
            xden    <= sh;
            ynum    <= 9'(bh);
            yden    <= 14'(sh);
            div_d   <= 22'(bw) * 22'(sh);
            divisor <= 9'(bh) << adbl;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_t >= {1'b0, divisor}) begin
            div_r <= 9'(div_t - {1'b0, divisor});
            div_d <= {div_d[20:0], 1'b1};
          end else begin
            div_r <= div_t[8:0];
            div_d <= {div_d[20:0], 1'b0};
          end
        end
        ST_OFF: begin
          bndx <= 22'(bw) * 22'(xden);
          bndy <= 22'(bh) * 22'(yden);
          if (fitw) begin
            xoff <= '0;
            yoff <= 13'((23'(sh) - 23'(div_q)) >> 1);
          end else begin
            xoff <= 13'((23'(sw) - 23'(div_q)) >> 1);
            yoff <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv, take;
  assign adv         = !results.valid || results.ready;
  assign items.ready = adv && !cfg_busy;
  assign take        = items.valid && items.ready;

  // stage 1: offset subtract
  logic               v1, f1;
  logic [10:0]        la1;
  logic [7:0]         lb1, pin1;
  logic signed [13:0] dx1, dy1;

  // stage 2: multiply
  logic        v2, f2, negx2, negy2;
  logic [10:0] la2;
  logic [7:0]  lb2, pin2;
  logic [21:0] prx2, pry2;
  logic [12:0] magx, magy;

  // stages 3..7: range check then two quotient bits per stage
  logic        vd[5];
  logic        fd[5];
  logic        od[5];
  logic [10:0] lad[5];
  logic [7:0]  lbd[5];
  logic [7:0]  pind[5];
  logic [21:0] remx[5];
  logic [21:0] remy[5];
  logic [7:0]  qx[5];
  logic [7:0]  qy[5];
  logic        outx, outy;

  // stage 8: address
  logic             v8, f8, hit8, wen8;
  logic [IDX_W-1:0] ra8, wa8;
  logic [2:0]       bp8;
  logic [7:0]       lb8, pin8;
  logic [5:0]       rowbytes;
  logic [AW-1:0]    raddr, waddr;

  // stage 9: bitmap RAM
  logic       v9, f9, hit9;
  logic [2:0] bp9;
  logic [7:0] pin9, rd9;
  logic [7:0] mem [DEPTH];
  logic       fg;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1   <= items.func;
      la1  <= items.load_addr;
      lb1  <= items.load_byte;
      pin1 <= items.pixel_in;
      dx1  <= $signed({2'b00, items.pixel_x}) - $signed({1'b0, xoff});
      dy1  <= $signed({2'b00, items.pixel_y}) - $signed({1'b0, yoff});
    end
  end

  assign magx = dx1[13] ? 13'(-dx1) : 13'(dx1);
  assign magy = dy1[13] ? 13'(-dy1) : 13'(dy1);

  always_ff @(posedge clk) begin
    if (adv) begin
      f2    <= f1;
      la2   <= la1;
      lb2   <= lb1;
      pin2  <= pin1;
      negx2 <= dx1[13];
      negy2 <= dy1[13];
      prx2  <= 22'(magx) * 22'(xnum);
      pry2  <= 22'(magy) * 22'(ynum);
    end
  end

  // out of bitmap: zero denominator, negative at or below -1, or past the far edge
  assign outx = (xden == 13'd0) ||
                (negx2 ? (prx2 >= 22'(xden) || bw == 8'd0) : (prx2 >= bndx));
  assign outy = (yden == 14'd0) ||
                (negy2 ? (pry2 >= 22'(yden) || bh == 8'd0) : (pry2 >= bndy));

  always_ff @(posedge clk) begin
    if (adv) begin
      fd[0]   <= f2;
      lad[0]  <= la2;
      lbd[0]  <= lb2;
      pind[0] <= pin2;
      od[0]   <= outx || outy;
      remx[0] <= prx2;
      remy[0] <= pry2;
      qx[0]   <= '0;
      qy[0]   <= '0;
    end
  end

  // quotient stages, MSB first
  for (genvar k = 0; k < 4; k++) begin : g_div
    logic [22:0] sxa, sxb, sya, syb;
    assign sxa = div_step(remx[k], 22'(xden) << (7 - 2 * k));
    assign sxb = div_step(sxa[21:0], 22'(xden) << (6 - 2 * k));
    assign sya = div_step(remy[k], 22'(yden) << (7 - 2 * k));
    assign syb = div_step(sya[21:0], 22'(yden) << (6 - 2 * k));

    always_ff @(posedge clk) begin
      if (rst)      vd[k+1] <= 1'b0;
      else if (adv) vd[k+1] <= vd[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fd[k+1]   <= fd[k];
        od[k+1]   <= od[k];
        lad[k+1]  <= lad[k];
        lbd[k+1]  <= lbd[k];
        pind[k+1] <= pind[k];
        remx[k+1] <= sxb[21:0];
        remy[k+1] <= syb[21:0];
        qx[k+1]   <= {qx[k][5:0], sxa[22], sxb[22]};
        qy[k+1]   <= {qy[k][5:0], sya[22], syb[22]};
      end
    end
  end

  // byte address of the mapped bit
  assign rowbytes = 6'((9'(bw) + 9'd7) >> 3);
  assign raddr    = AW'(14'(rowbytes) * 14'(qy[4])) + AW'(qx[4][7:3]);
  assign waddr    = AW'(lad[4]);

  always_ff @(posedge clk) begin
    if (adv) begin
      f8   <= fd[4];
      hit8 <= !od[4] && (raddr < AW'(DEPTH));
      wen8 <= waddr < AW'(DEPTH);
      ra8  <= raddr[IDX_W-1:0];
      wa8  <= waddr[IDX_W-1:0];
      bp8  <= qx[4][2:0];
      lb8  <= lbd[4];
      pin8 <= pind[4];
    end
  end

  // loads write at the same stage tests read, so order is kept
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v8 && f8 == FUNC_LOAD && wen8) mem[wa8] <= lb8;
      rd9  <= mem[ra8];
      f9   <= f8;
      hit9 <= hit8;
      bp9  <= bp8;
      pin9 <= pin8;
    end
  end

  assign fg = hit9 && rd9[bp9];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; vd[0] <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      v1            <= take;
      v2            <= v1;
      vd[0]         <= v2;
      v8            <= vd[4];
      v9            <= v8;
      results.valid <= v9 && f9 == FUNC_TEST;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (adv) begin
      results.foreground <= fg;
      results.pixel_out  <= fg ? FG_PIXEL : pin9;
    end
  end

  // checks
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_busy |-> !items.ready)
    else $error("input taken during scale recompute");

  a_cfg_starts_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cfg.valid && cfg_hit) |=> state == ST_MUL)
    else $error("register write did not start recompute");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt < 5'(DIV_STEPS))
    else $error("divide count overrun");

  a_fg_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.foreground) |-> results.pixel_out == FG_PIXEL)
    else $error("foreground word without overlay value");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> v9 == $past(v9) && v8 == $past(v8))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
